// File: design/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// Shared widths, pipeline depths and types of the cylinder support point core.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int FRAC_BITS = 16;             // fractional bits of all values
  localparam int DW        = 32;             // coordinate width
  localparam int AW        = 18;             // axis component width
  localparam int LW        = 31;             // radius / height width
  localparam int VW        = DW + 2;         // normalizer input width
  localparam int MW        = DW - 1;         // prescaled magnitude width
  localparam int SW        = 2 * MW + 2;     // sum of squares width
  localparam int RW        = SW / 2;         // square root width
  localparam int QW        = FRAC_BITS + 1;  // quotient bits (|q| <= 1.0)
  localparam int UW        = QW + 1;         // signed unit component width

  localparam int SQ_PER    = 2;              // root bits per stage
  localparam int SQ_STG    = RW / SQ_PER;
  localparam int DIV_PER   = 3;              // quotient bits per stage
  localparam int DIV_STG   = (QW + DIV_PER - 1) / DIV_PER;
  localparam int NORM_LAT  = 4 + SQ_STG + DIV_STG;

  localparam int PDW       = 32;             // APB data width
  localparam int PAW       = 5;              // APB address width

  typedef logic signed [VW-1:0] vin_t;
  typedef logic signed [UW-1:0] unit_t;

  typedef struct packed {
    logic        [LW-1:0] radius;
    logic        [LW-1:0] height;
    logic signed [DW-1:0] center_x;
    logic signed [DW-1:0] center_y;
    logic signed [DW-1:0] center_z;
    logic signed [AW-1:0] axis_x;
    logic signed [AW-1:0] axis_y;
    logic signed [AW-1:0] axis_z;
  } cfg_t;

endpackage

// File: design/csp_if.sv
// ----------------------------------------------------------------------------
// csp_if
// Valid/ready channels: search direction in, support point out.
// ----------------------------------------------------------------------------
interface csp_dir_if;
  logic                        valid;
  logic                        ready;
  logic signed [csp_pkg::DW-1:0] dir_x;
  logic signed [csp_pkg::DW-1:0] dir_y;
  logic signed [csp_pkg::DW-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface csp_point_if;
  logic                        valid;
  logic                        ready;
  logic signed [csp_pkg::DW-1:0] point_x;
  logic signed [csp_pkg::DW-1:0] point_y;
  logic signed [csp_pkg::DW-1:0] point_z;
  logic                        saturated;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output saturated, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  input saturated, output ready);
endinterface

// File: design/csp_cfg.sv
// ----------------------------------------------------------------------------
// csp_cfg
// APB register file: radius, height, center and rotated axis.
// ----------------------------------------------------------------------------
module csp_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [csp_pkg::PAW-1:0]   paddr,
  input  logic [csp_pkg::PDW-1:0]   pwdata,
  output logic [csp_pkg::PDW-1:0]   prdata,
  output logic                      pready,
  output csp_pkg::cfg_t             cfg_o
);

  localparam logic [2:0] REG_RADIUS   = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_CENTER_X = 3'd2;
  localparam logic [2:0] REG_CENTER_Y = 3'd3;
  localparam logic [2:0] REG_CENTER_Z = 3'd4;
  localparam logic [2:0] REG_AXIS_X   = 3'd5;
  localparam logic [2:0] REG_AXIS_Y   = 3'd6;
  localparam logic [2:0] REG_AXIS_Z   = 3'd7;

  // reset setup: empty cylinder at the origin, axis along +x
  localparam csp_pkg::cfg_t CFG_RST = '{
    radius:   '0,
    height:   '0,
    center_x: '0,
    center_y: '0,
    center_z: '0,
    axis_x:   csp_pkg::AW'(1 << csp_pkg::FRAC_BITS),
    axis_y:   '0,
    axis_z:   '0
  };

  csp_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]    idx;
  logic          wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        REG_RADIUS:   cfg_d.radius   = pwdata[csp_pkg::LW-1:0];
        REG_HEIGHT:   cfg_d.height   = pwdata[csp_pkg::LW-1:0];
        REG_CENTER_X: cfg_d.center_x = pwdata[csp_pkg::DW-1:0];
        REG_CENTER_Y: cfg_d.center_y = pwdata[csp_pkg::DW-1:0];
        REG_CENTER_Z: cfg_d.center_z = pwdata[csp_pkg::DW-1:0];
        REG_AXIS_X:   cfg_d.axis_x   = pwdata[csp_pkg::AW-1:0];
        REG_AXIS_Y:   cfg_d.axis_y   = pwdata[csp_pkg::AW-1:0];
        REG_AXIS_Z:   cfg_d.axis_z   = pwdata[csp_pkg::AW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_RADIUS:   prdata = csp_pkg::PDW'(cfg_q.radius);
      REG_HEIGHT:   prdata = csp_pkg::PDW'(cfg_q.height);
      REG_CENTER_X: prdata = csp_pkg::PDW'(cfg_q.center_x);
      REG_CENTER_Y: prdata = csp_pkg::PDW'(cfg_q.center_y);
      REG_CENTER_Z: prdata = csp_pkg::PDW'(cfg_q.center_z);
      REG_AXIS_X:   prdata = csp_pkg::PDW'($signed(cfg_q.axis_x));
      REG_AXIS_Y:   prdata = csp_pkg::PDW'($signed(cfg_q.axis_y));
      REG_AXIS_Z:   prdata = csp_pkg::PDW'($signed(cfg_q.axis_z));
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/csp_norm.sv
// ----------------------------------------------------------------------------
// csp_norm
// Pipelined 3-vector normalizer: prescale, squares, digit-serial root stages,
// restoring divide stages, sign restore. Zero input gives a zero vector.
// ----------------------------------------------------------------------------
module csp_norm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  csp_pkg::vin_t  v_i [3],
  output logic           valid_o,
  output logic           zero_o,
  output csp_pkg::unit_t u_o [3]
);

  localparam int XW  = csp_pkg::VW - csp_pkg::MW;
  localparam int SHW = $clog2(XW + 1);
  localparam int RMW = csp_pkg::RW + 3;
  localparam int DRW = csp_pkg::RW + csp_pkg::FRAC_BITS;

  typedef struct packed {
    logic [2:0][csp_pkg::MW-1:0] m;
    logic [2:0]                  neg;
    logic                        zero;
  } sb_t;

  // prescale
  sb_t  p_sb_d, p_sb_q;
  logic p_vld_q;

  always_comb begin
    logic [csp_pkg::VW-1:0] mag [3];
    logic [csp_pkg::VW-1:0] mx;
    logic [SHW-1:0]         sh;
    mx = '0;
    for (int i = 0; i < 3; i++) begin
      p_sb_d.neg[i] = v_i[i][csp_pkg::VW-1];
      mag[i] = p_sb_d.neg[i] ? csp_pkg::VW'(-v_i[i]) : csp_pkg::VW'(v_i[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    sh = '0;
    for (int j = 0; j < XW; j++) begin
      if (mx[csp_pkg::MW+j]) sh = SHW'(j + 1);
    end
    for (int i = 0; i < 3; i++) p_sb_d.m[i] = csp_pkg::MW'(mag[i] >> sh);
    p_sb_d.zero = (mx == '0);
  end

  // squares
  logic [2*csp_pkg::MW-1:0] sq_q [3];
  sb_t  q_sb_q;
  logic q_vld_q;

  // sum
  logic [csp_pkg::SW-1:0] sum_q;
  sb_t  s_sb_q;
  logic s_vld_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_sb_q <= p_sb_d;
      for (int i = 0; i < 3; i++) sq_q[i] <= p_sb_q.m[i] * p_sb_q.m[i];
      q_sb_q <= p_sb_q;
      sum_q  <= csp_pkg::SW'(sq_q[0]) + csp_pkg::SW'(sq_q[1]) + csp_pkg::SW'(sq_q[2]);
      s_sb_q <= q_sb_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      q_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
    end else if (en_i) begin
      p_vld_q <= valid_i;
      q_vld_q <= p_vld_q;
      s_vld_q <= q_vld_q;
    end
  end

  // square root, SQ_PER result bits per stage
  logic [csp_pkg::SW-1:0] sqv_q  [csp_pkg::SQ_STG];
  logic [RMW-1:0]         rem_q  [csp_pkg::SQ_STG];
  logic [csp_pkg::RW-1:0] root_q [csp_pkg::SQ_STG];
  sb_t                    ssb_q  [csp_pkg::SQ_STG];
  logic                   svld_q [csp_pkg::SQ_STG];

  for (genvar g = 0; g < csp_pkg::SQ_STG; g++) begin : g_sqrt
    logic [csp_pkg::SW-1:0] v_in;
    logic [RMW-1:0]         rem_in, rem_d;
    logic [csp_pkg::RW-1:0] root_in, root_d;
    sb_t                    sb_in;
    logic                   vld_in;

    if (g == 0) begin : g_first
      assign v_in    = sum_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sb_in   = s_sb_q;
      assign vld_in  = s_vld_q;
    end else begin : g_next
      assign v_in    = sqv_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign sb_in   = ssb_q[g-1];
      assign vld_in  = svld_q[g-1];
    end

    always_comb begin
      logic [RMW-1:0]         r;
      logic [csp_pkg::RW-1:0] rt;
      logic [RMW-1:0]         trial;
      r  = rem_in;
      rt = root_in;
      for (int k = 0; k < csp_pkg::SQ_PER; k++) begin
        r     = {r[RMW-3:0], v_in[csp_pkg::SW-1-2*(g*csp_pkg::SQ_PER+k) -: 2]};
        trial = RMW'({rt, 2'b01});
        if (r >= trial) begin
          r  = r - trial;
          rt = {rt[csp_pkg::RW-2:0], 1'b1};
        end else begin
          rt = {rt[csp_pkg::RW-2:0], 1'b0};
        end
      end
      rem_d  = r;
      root_d = rt;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sqv_q[g]  <= v_in;
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
        ssb_q[g]  <= sb_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        svld_q[g] <= 1'b0;
      end else if (en_i) begin
        svld_q[g] <= vld_in;
      end
    end
  end

  // restoring divide (m << FRAC_BITS) / len, DIV_PER quotient bits per stage
  logic [DRW-1:0]         dr_q   [csp_pkg::DIV_STG][3];
  logic [csp_pkg::QW-1:0] dq_q   [csp_pkg::DIV_STG][3];
  logic [csp_pkg::RW-1:0] dlen_q [csp_pkg::DIV_STG];
  sb_t                    dsb_q  [csp_pkg::DIV_STG];
  logic                   dvld_q [csp_pkg::DIV_STG];

  for (genvar g = 0; g < csp_pkg::DIV_STG; g++) begin : g_div
    logic [DRW-1:0]         r_in [3];
    logic [DRW-1:0]         r_d  [3];
    logic [csp_pkg::QW-1:0] q_in [3];
    logic [csp_pkg::QW-1:0] q_d  [3];
    logic [csp_pkg::RW-1:0] l_in;
    sb_t                    sb_in;
    logic                   vld_in;

    if (g == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          r_in[i] = DRW'(ssb_q[csp_pkg::SQ_STG-1].m[i]) << csp_pkg::FRAC_BITS;
          q_in[i] = '0;
        end
      end
      assign l_in   = root_q[csp_pkg::SQ_STG-1];
      assign sb_in  = ssb_q[csp_pkg::SQ_STG-1];
      assign vld_in = svld_q[csp_pkg::SQ_STG-1];
    end else begin : g_next
      assign r_in   = dr_q[g-1];
      assign q_in   = dq_q[g-1];
      assign l_in   = dlen_q[g-1];
      assign sb_in  = dsb_q[g-1];
      assign vld_in = dvld_q[g-1];
    end

    always_comb begin
      logic [DRW-1:0]         r;
      logic [csp_pkg::QW-1:0] q;
      logic [DRW-1:0]         trial;
      for (int i = 0; i < 3; i++) begin
        r = r_in[i];
        q = q_in[i];
        for (int k = 0; k < csp_pkg::DIV_PER; k++) begin
          if (g * csp_pkg::DIV_PER + k < csp_pkg::QW) begin
            trial = DRW'(l_in) << (csp_pkg::QW - 1 - (g * csp_pkg::DIV_PER + k));
            if (r >= trial) begin
              r = r - trial;
              q = {q[csp_pkg::QW-2:0], 1'b1};
            end else begin
              q = {q[csp_pkg::QW-2:0], 1'b0};
            end
          end
        end
        r_d[i] = r;
        q_d[i] = q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dr_q[g]   <= r_d;
        dq_q[g]   <= q_d;
        dlen_q[g] <= l_in;
        dsb_q[g]  <= sb_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvld_q[g] <= 1'b0;
      end else if (en_i) begin
        dvld_q[g] <= vld_in;
      end
    end
  end

  // sign restore
  csp_pkg::unit_t u_q [3];
  logic           zero_q, vld_q;
  sb_t            lsb;

  assign lsb = dsb_q[csp_pkg::DIV_STG-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q <= lsb.zero;
      for (int i = 0; i < 3; i++) begin
        if (lsb.zero) begin
          u_q[i] <= '0;
        end else if (lsb.neg[i]) begin
          u_q[i] <= -$signed({1'b0, dq_q[csp_pkg::DIV_STG-1][i]});
        end else begin
          u_q[i] <= $signed({1'b0, dq_q[csp_pkg::DIV_STG-1][i]});
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= dvld_q[csp_pkg::DIV_STG-1];
    end
  end

  assign valid_o = vld_q;
  assign zero_o  = zero_q;
  assign u_o     = u_q;

endmodule

// File: design/cylinder_support_point_core.sv
// ----------------------------------------------------------------------------
// cylinder_support_point_core
// GJK support point of a finite cylinder for a Q16.16 search direction.
// ----------------------------------------------------------------------------
// Usage:
//  - dir_i (sink): one search direction per transfer, dir_x/y/z Q16.16.
//  - point_o (source): one support point per direction, in order, with a
//    saturated flag when any coordinate was clamped to 32 bits.
//  - APB port: radius, height, center_x/y/z, axis_x/y/z at byte 4*i. Write
//    only while no transfer is in flight. pready is tied high.
//  - Throughput: one direction per cycle while point_o is not stalled.
//  - Path: three normalizers in series (the two offset normalizers run side
//    by side), 26 stages each, dominate the path from input transfer to
//    point_o.valid (root: 2 bits/stage over 32 bits, divide: 3 quotient
//    bits/stage over 17 bits); the remaining stages are dot products,
//    projection, offsets and the final select/saturate.
//  - Stall: all stages advance on one enable, held while point_o holds a
//    result that is not taken; dir_i.ready drops at the same time. Nothing
//    is lost or repeated.
//  - Reset: all valid bits clear, the pipe is empty, registers take their
//    defaults (axis = +x, all else zero).
// ----------------------------------------------------------------------------
module cylinder_support_point_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  csp_dir_if.sink                 dir_i,
  csp_point_if.source             point_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [csp_pkg::PAW-1:0] paddr,
  input  logic [csp_pkg::PDW-1:0] pwdata,
  output logic [csp_pkg::PDW-1:0] prdata,
  output logic                    pready
);

  localparam int F    = csp_pkg::FRAC_BITS;
  localparam int UW   = csp_pkg::UW;
  localparam int AW   = csp_pkg::AW;
  localparam int VW   = csp_pkg::VW;
  localparam int DW   = csp_pkg::DW;
  localparam int NL   = csp_pkg::NORM_LAT;
  localparam int P1W  = UW + AW;          // n * a
  localparam int S1W  = P1W + 2;          // sum of three
  localparam int DTW  = S1W - F;          // dot after shift
  localparam int TW   = DTW + AW;         // dot * a
  localparam int HPW  = AW + csp_pkg::LW + 1;
  localparam int SHW  = HPW - F - 1;      // half height along axis
  localparam int RPPW = UW + csp_pkg::LW + 1;
  localparam int RPW  = RPPW - F;         // projection times radius
  localparam int P2W  = 2 * UW;           // n * u
  localparam int S2W  = P2W + 2;          // score
  localparam int CW   = DW + 3;           // center + offset

  csp_pkg::cfg_t cfg;

  csp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic signed [AW-1:0] ax  [3];
  logic signed [DW-1:0] cen [3];
  assign ax[0]  = cfg.axis_x;
  assign ax[1]  = cfg.axis_y;
  assign ax[2]  = cfg.axis_z;
  assign cen[0] = cfg.center_x;
  assign cen[1] = cfg.center_y;
  assign cen[2] = cfg.center_z;

  // global advance: stall everything while a result waits
  logic en, out_vld_q;
  assign en          = !out_vld_q || point_o.ready;
  assign dir_i.ready = en;

  // ---- stage A: normalize direction
  csp_pkg::vin_t  d_in [3];
  csp_pkg::unit_t n1_u [3];
  logic           n1_vld, n1_zero;

  assign d_in[0] = VW'(dir_i.dir_x);
  assign d_in[1] = VW'(dir_i.dir_y);
  assign d_in[2] = VW'(dir_i.dir_z);

  csp_norm u_norm_dir (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (dir_i.valid),
    .v_i (d_in), .valid_o (n1_vld), .zero_o (n1_zero), .u_o (n1_u)
  );

  // ---- stage B: project onto cap plane
  csp_pkg::unit_t        n_c [3];
  csp_pkg::unit_t        nb1_q [3], nb2_q [3], nb3_q [3], nb4_q [3];
  logic signed [P1W-1:0] pa_q [3];
  logic signed [S1W-1:0] dsum;
  logic signed [DTW-1:0] dt_q;
  logic signed [TW-1:0]  t_q [3];
  logic signed [HPW-1:0] hp [3];
  logic signed [SHW-1:0] shb3_q [3], shb4_q [3];
  csp_pkg::vin_t         p_q [3];
  logic                  vb1_q, vb2_q, vb3_q, vb4_q;

  // zero direction stands for +x at unit scale
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (n1_zero) begin
        n_c[i] = (i == 0) ? UW'(1 << F) : '0;
      end else begin
        n_c[i] = n1_u[i];
      end
    end
  end

  assign dsum = S1W'(pa_q[0]) + S1W'(pa_q[1]) + S1W'(pa_q[2]);

  always_comb begin
    for (int i = 0; i < 3; i++) hp[i] = ax[i] * $signed({1'b0, cfg.height});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa_q[i]   <= n_c[i] * ax[i];
        nb1_q[i]  <= n_c[i];
        nb2_q[i]  <= nb1_q[i];
        t_q[i]    <= dt_q * ax[i];
        shb3_q[i] <= SHW'(hp[i] >>> (F + 1));
        nb3_q[i]  <= nb2_q[i];
        p_q[i]    <= VW'(TW'(nb3_q[i]) - (t_q[i] >>> F));
        shb4_q[i] <= shb3_q[i];
        nb4_q[i]  <= nb3_q[i];
      end
      dt_q <= DTW'(dsum >>> F);
    end
  end

  // ---- stage C: normalize projection, sidebands ride along
  csp_pkg::unit_t        pn_u [3];
  logic                  n2_vld, n2_zero;
  csp_pkg::unit_t        nc_q  [NL][3];
  logic signed [SHW-1:0] shc_q [NL][3];

  csp_norm u_norm_proj (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (vb4_q),
    .v_i (p_q), .valid_o (n2_vld), .zero_o (n2_zero), .u_o (pn_u)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      nc_q[0]  <= nb4_q;
      shc_q[0] <= shb4_q;
      for (int j = 1; j < NL; j++) begin
        nc_q[j]  <= nc_q[j-1];
        shc_q[j] <= shc_q[j-1];
      end
    end
  end

  // ---- stage D: candidate offsets
  logic signed [RPPW-1:0] rpp [3];
  logic signed [RPW-1:0]  rp_q [3];
  logic signed [SHW-1:0]  shd_q [3];
  csp_pkg::unit_t         nd1_q [3], nd2_q [3];
  csp_pkg::vin_t          off1_q [3], off2_q [3];
  logic                   vd1_q, vd2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) rpp[i] = pn_u[i] * $signed({1'b0, cfg.radius});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rp_q[i]   <= RPW'(rpp[i] >>> F);
        shd_q[i]  <= shc_q[NL-1][i];
        nd1_q[i]  <= nc_q[NL-1][i];
        off1_q[i] <= VW'((RPW + 1)'(rp_q[i]) + (RPW + 1)'(shd_q[i]));
        off2_q[i] <= VW'((RPW + 1)'(rp_q[i]) - (RPW + 1)'(shd_q[i]));
        nd2_q[i]  <= nd1_q[i];
      end
    end
  end

  // ---- stage E: normalize both offsets
  csp_pkg::unit_t u1_u [3], u2_u [3];
  logic           n3_vld, n3_zero, n4_vld, n4_zero;
  csp_pkg::unit_t ne_q  [NL][3];
  csp_pkg::vin_t  o1e_q [NL][3];
  csp_pkg::vin_t  o2e_q [NL][3];

  csp_norm u_norm_off1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (vd2_q),
    .v_i (off1_q), .valid_o (n3_vld), .zero_o (n3_zero), .u_o (u1_u)
  );

  csp_norm u_norm_off2 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (vd2_q),
    .v_i (off2_q), .valid_o (n4_vld), .zero_o (n4_zero), .u_o (u2_u)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      ne_q[0]  <= nd2_q;
      o1e_q[0] <= off1_q;
      o2e_q[0] <= off2_q;
      for (int j = 1; j < NL; j++) begin
        ne_q[j]  <= ne_q[j-1];
        o1e_q[j] <= o1e_q[j-1];
        o2e_q[j] <= o2e_q[j-1];
      end
    end
  end

  // ---- stage F: score, select, saturate
  logic signed [P2W-1:0] s1p_q [3], s2p_q [3];
  csp_pkg::vin_t         o1f_q [3], o2f_q [3], osel_q [3];
  logic signed [S2W-1:0] s1, s2;
  logic                  vf1_q, vf2_q;
  logic signed [CW-1:0]  pv [3];
  logic signed [DW-1:0]  pt_c [3], pt_q [3];
  logic [2:0]            clip;
  logic                  sat_q;

  assign s1 = S2W'(s1p_q[0]) + S2W'(s1p_q[1]) + S2W'(s1p_q[2]);
  assign s2 = S2W'(s2p_q[0]) + S2W'(s2p_q[1]) + S2W'(s2p_q[2]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pv[i] = CW'(cen[i]) + CW'(osel_q[i]);
      // out of range when the bits above the sign do not all agree
      clip[i] = !((pv[i][CW-1:DW-1] == '0) || (pv[i][CW-1:DW-1] == '1));
      if (!clip[i]) begin
        pt_c[i] = pv[i][DW-1:0];
      end else if (pv[i][CW-1]) begin
        pt_c[i] = {1'b1, {(DW-1){1'b0}}};
      end else begin
        pt_c[i] = {1'b0, {(DW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1p_q[i] <= ne_q[NL-1][i] * u1_u[i];
        s2p_q[i] <= ne_q[NL-1][i] * u2_u[i];
        o1f_q[i] <= o1e_q[NL-1][i];
        o2f_q[i] <= o2e_q[NL-1][i];
        // ties go to the minus-axis candidate
        osel_q[i] <= (s1 > s2) ? o1f_q[i] : o2f_q[i];
        pt_q[i]   <= pt_c[i];
      end
      sat_q <= |clip;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb1_q     <= 1'b0;
      vb2_q     <= 1'b0;
      vb3_q     <= 1'b0;
      vb4_q     <= 1'b0;
      vd1_q     <= 1'b0;
      vd2_q     <= 1'b0;
      vf1_q     <= 1'b0;
      vf2_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vb1_q     <= n1_vld;
      vb2_q     <= vb1_q;
      vb3_q     <= vb2_q;
      vb4_q     <= vb3_q;
      vd1_q     <= n2_vld;
      vd2_q     <= vd1_q;
      vf1_q     <= n3_vld;
      vf2_q     <= vf1_q;
      out_vld_q <= vf2_q;
    end
  end

  assign point_o.valid     = out_vld_q;
  assign point_o.point_x   = pt_q[0];
  assign point_o.point_y   = pt_q[1];
  assign point_o.point_z   = pt_q[2];
  assign point_o.saturated = sat_q;

`ifndef SYNTHESIS
  // a saturated result sits on a rail in at least one coordinate
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point_o.valid && point_o.saturated) |->
      (point_o.point_x == {1'b0, {(DW-1){1'b1}}} || point_o.point_x == {1'b1, {(DW-1){1'b0}}} ||
       point_o.point_y == {1'b0, {(DW-1){1'b1}}} || point_o.point_y == {1'b1, {(DW-1){1'b0}}} ||
       point_o.point_z == {1'b0, {(DW-1){1'b1}}} || point_o.point_z == {1'b1, {(DW-1){1'b0}}}))
    else $error("saturated flag without clamped coordinate");

  // an empty output register never blocks the input
  a_bubble_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !point_o.valid |-> dir_i.ready)
    else $error("input stalled with empty output");

  // both offset normalizers run in lockstep
  a_off_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n3_vld == n4_vld)
    else $error("offset normalizers out of step");

  // a zero projection normalizes to the zero vector
  a_proj_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n2_vld && n2_zero) |-> (pn_u[0] == '0 && pn_u[1] == '0 && pn_u[2] == '0))
    else $error("zero projection gave nonzero unit vector");

  // a zero offset normalizes to the zero vector (score zero)
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n3_vld |->
      ((!n3_zero || (u1_u[0] == '0 && u1_u[1] == '0 && u1_u[2] == '0)) &&
       (!n4_zero || (u2_u[0] == '0 && u2_u[1] == '0 && u2_u[2] == '0))))
    else $error("zero offset gave nonzero unit vector");
`endif

endmodule

// File: test/cylinder_support_point_core_test.sv
// ----------------------------------------------------------------------------
// cylinder_support_point_core_test
// Self-checking bench: random and directed search directions over several
// cylinder setups, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cylinder_support_point_core_test;

  localparam int FB        = csp_pkg::FRAC_BITS;
  localparam int DW        = csp_pkg::DW;
  localparam int AW        = csp_pkg::AW;
  localparam int PAW       = csp_pkg::PAW;
  localparam int PDW       = csp_pkg::PDW;
  localparam int LATENCY   = 87;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1900;

  // register indexes of the APB map
  typedef enum int {
    REG_RADIUS, REG_HEIGHT, REG_CX, REG_CY, REG_CZ, REG_AX, REG_AY, REG_AZ
  } reg_idx_e;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } dir_item_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic                 sat;
  } point_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PAW-1:0] paddr = '0;
  logic [PDW-1:0] pwdata = '0;
  logic [PDW-1:0] prdata;
  logic pready;

  csp_dir_if   dir_ch ();
  csp_point_if pt_ch ();

  cylinder_support_point_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dir_i   (dir_ch.sink),
    .point_o (pt_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the cylinder setup
  longint cyl_radius, cyl_height;
  longint cyl_center [3];
  longint cyl_axis [3];

  dir_item_t   pending_dirs [$];
  point_item_t expected_points [$];
  int  errors = 0;
  int  points_seen = 0;
  bit  send_en = 1'b0;

  // ---------------------------------------------------------------- predictor
  function automatic longint fshift(longint v, int s);
    return v >>> s; // arithmetic shift floors
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit vector with FB fraction bits; zero in gives zero out
  task automatic unit_vec(input longint v [3], output longint o [3]);
    longint unsigned m [3];
    longint unsigned mx, sum, len;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? longint'(0) - v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
    end else begin
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        o[i] = longint'((m[i] << FB) / len);
        if (v[i] < 0) o[i] = -o[i];
      end
    end
  endtask

  task automatic predict_support(input dir_item_t d, output point_item_t r);
    longint dv [3], n [3], p [3], pn [3], o1 [3], o2 [3], u1 [3], u2 [3];
    longint dt, s1, s2, v;
    logic [2:0] clamp;
    dv[0] = d.x; dv[1] = d.y; dv[2] = d.z;
    if (d.x == 0 && d.y == 0 && d.z == 0) begin
      n[0] = longint'(1) << FB; n[1] = 0; n[2] = 0;
    end else begin
      unit_vec(dv, n);
    end
    dt = fshift(n[0]*cyl_axis[0] + n[1]*cyl_axis[1] + n[2]*cyl_axis[2], FB);
    for (int i = 0; i < 3; i++) p[i] = n[i] - fshift(dt * cyl_axis[i], FB);
    unit_vec(p, pn);
    for (int i = 0; i < 3; i++) begin
      o1[i] = fshift(pn[i] * cyl_radius, FB) + fshift(cyl_axis[i] * cyl_height, FB + 1);
      o2[i] = fshift(pn[i] * cyl_radius, FB) - fshift(cyl_axis[i] * cyl_height, FB + 1);
    end
    unit_vec(o1, u1);
    unit_vec(o2, u2);
    s1 = n[0]*u1[0] + n[1]*u1[1] + n[2]*u1[2];
    s2 = n[0]*u2[0] + n[1]*u2[1] + n[2]*u2[2];
    clamp = '0;
    for (int i = 0; i < 3; i++) begin
      v = cyl_center[i] + (s1 > s2 ? o1[i] : o2[i]);
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647; clamp[i] = 1'b1;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648; clamp[i] = 1'b1;
      end
      if (i == 0) r.x = v[31:0];
      else if (i == 1) r.y = v[31:0];
      else r.z = v[31:0];
    end
    r.sat = |clamp;
  endtask

  // ---------------------------------------------------------------- driver
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_ch.valid <= 1'b0;
      dir_ch.dir_x <= '0;
      dir_ch.dir_y <= '0;
      dir_ch.dir_z <= '0;
    end else begin
      automatic bit busy = dir_ch.valid && !dir_ch.ready;
      automatic point_item_t pr;
      if (dir_ch.valid && dir_ch.ready) begin
        // transfer done: predict from what was on the bus
        predict_support('{dir_ch.dir_x, dir_ch.dir_y, dir_ch.dir_z}, pr);
        expected_points.push_back(pr);
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          dir_ch.valid <= 1'b0;
        end else if (send_en && pending_dirs.size() > 0) begin
          automatic dir_item_t nx = pending_dirs.pop_front();
          dir_ch.valid <= 1'b1;
          dir_ch.dir_x <= nx.x;
          dir_ch.dir_y <= nx.y;
          dir_ch.dir_z <= nx.z;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          dir_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int stall_mode = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_ch.ready <= 1'b0;
    end else begin
      if (pt_ch.valid && pt_ch.ready) begin
        automatic point_item_t got = '{pt_ch.point_x, pt_ch.point_y, pt_ch.point_z,
                                       pt_ch.saturated};
        points_seen++;
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected point %h", $time, got);
          errors++;
        end else begin
          automatic point_item_t exp = expected_points.pop_front();
          if (got.x !== exp.x) begin
            $display("%0t: point_x expected %h actual %h", $time, exp.x, got.x);
            errors++;
          end
          if (got.y !== exp.y) begin
            $display("%0t: point_y expected %h actual %h", $time, exp.y, got.y);
            errors++;
          end
          if (got.z !== exp.z) begin
            $display("%0t: point_z expected %h actual %h", $time, exp.z, got.z);
            errors++;
          end
          if (got.sat !== exp.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, exp.sat, got.sat);
            errors++;
          end
        end
      end
      // receiver pattern: long open windows, periodic stalls, random chatter
      stall_mode <= (stall_mode + 1) % 256;
      if (stall_mode < 96) pt_ch.ready <= 1'b1;
      else if (stall_mode < 160) pt_ch.ready <= ($urandom_range(0, 2) != 0);
      else if (stall_mode < 176) pt_ch.ready <= 1'b0;
      else pt_ch.ready <= stall_mode[1];
    end
  end

  // ---------------------------------------------------------------- watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((dir_ch.valid && dir_ch.ready) || (pt_ch.valid && pt_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- APB
  task automatic reg_write(input reg_idx_e idx, input logic [PDW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= PAW'(4 * int'(idx)); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_RADIUS: cyl_radius = longint'(val[30:0]);
      REG_HEIGHT: cyl_height = longint'(val[30:0]);
      REG_CX:     cyl_center[0] = longint'(signed'(val));
      REG_CY:     cyl_center[1] = longint'(signed'(val));
      REG_CZ:     cyl_center[2] = longint'(signed'(val));
      REG_AX:     cyl_axis[0] = longint'(signed'(val[AW-1:0]));
      REG_AY:     cyl_axis[1] = longint'(signed'(val[AW-1:0]));
      default:    cyl_axis[2] = longint'(signed'(val[AW-1:0]));
    endcase
  endtask

  task automatic setup_cylinder(input longint r, input longint h, input longint cx,
                                input longint cy, input longint cz, input longint ax,
                                input longint ay, input longint az);
    reg_write(REG_RADIUS, r[31:0]);
    reg_write(REG_HEIGHT, h[31:0]);
    reg_write(REG_CX, cx[31:0]);
    reg_write(REG_CY, cy[31:0]);
    reg_write(REG_CZ, cz[31:0]);
    reg_write(REG_AX, ax[31:0]);
    reg_write(REG_AY, ay[31:0]);
    reg_write(REG_AZ, az[31:0]);
  endtask

  // wait for the pipe to drain fully before touching registers
  task automatic drain_pipe();
    wait (pending_dirs.size() == 0 && !dir_ch.valid && expected_points.size() == 0);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      2: return $signed($urandom_range(0, 255)) - 128;
      3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      4: return 0;
      default: return $signed($urandom_range(0, 1 << 24)) << $urandom_range(0, 7);
    endcase
  endfunction

  function automatic logic signed [17:0] rand_axis_c();
    return 18'($signed($urandom_range(0, 131072)) - 65536);
  endfunction

  task automatic queue_random(input int cnt);
    for (int k = 0; k < cnt; k++)
      pending_dirs.push_back('{rand_coord(), rand_coord(), rand_coord()});
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    int phase_items;
    cyl_radius = 0; cyl_height = 0;
    cyl_center = '{0, 0, 0};
    cyl_axis = '{65536, 0, 0};
    dir_ch.valid = 1'b0;
    dir_ch.dir_x = '0; dir_ch.dir_y = '0; dir_ch.dir_z = '0;
    pt_ch.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setup first: zero cylinder, axis +x
    pending_dirs.push_back('{0, 0, 0});
    pending_dirs.push_back('{32'sh10000, 0, 0});
    send_en = 1'b1;
    drain_pipe();

    // directed: unit cylinder along z, extremes and special directions
    setup_cylinder(65536, 131072, 0, 0, 0, 0, 0, 65536);
    pending_dirs.push_back('{0, 0, 0});                         // zero dir
    pending_dirs.push_back('{0, 0, 32'sh10000});                // along axis
    pending_dirs.push_back('{0, 0, -32'sh10000});               // against axis
    pending_dirs.push_back('{32'sh10000, 0, 0});                // in cap plane: tie
    pending_dirs.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
    pending_dirs.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000});
    pending_dirs.push_back('{32'sh80000000, 32'sh7fffffff, 0});
    pending_dirs.push_back('{1, 0, 0});
    pending_dirs.push_back('{-1, -1, -1});
    pending_dirs.push_back('{0, 32'sh80000000, 1});
    pending_dirs.push_back('{32'shffffffff, 32'sh55555555, 32'shaaaaaaaa});
    drain_pipe();

    // extremes: max size, far center to force clamping, non-unit axis
    setup_cylinder(32'h7fffffff, 32'h7fffffff, 32'sh7fffffff, 32'sh80000000, 0,
                   65536, -65536, 65536);
    pending_dirs.push_back('{0, 0, 0});
    pending_dirs.push_back('{32'sh10000, 32'sh10000, 0});
    pending_dirs.push_back('{-32'sh10000, 32'sh10000, 32'sh10000});
    pending_dirs.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
    drain_pipe();

    // zero radius, zero height (all offsets zero) with axis -x
    setup_cylinder(0, 0, 32'sh123, -32'sh456, 32'sh789, -65536, 0, 0);
    pending_dirs.push_back('{32'sh10000, 0, 0});
    pending_dirs.push_back('{0, 32'sh10000, 0});
    drain_pipe();

    // random phases over random setups
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: setup_cylinder($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 21),
                          $signed($urandom_range(0, 1 << 22)) - (1 << 21), 0,
                          $signed($urandom_range(0, 1 << 22)) - (1 << 21),
                          0, 65536, 0);
        1: setup_cylinder($urandom & 32'h7fffffff, $urandom & 32'h7fffffff,
                          $urandom, $urandom, $urandom,
                          rand_axis_c(), rand_axis_c(), rand_axis_c());
        2: setup_cylinder($urandom_range(0, 1 << 18), $urandom_range(0, 1 << 18),
                          0, 0, 0, 46341, 46341, 0);
        default: setup_cylinder($urandom_range(0, 1 << 24), $urandom_range(0, 1 << 24),
                                $urandom, $urandom, $urandom,
                                rand_axis_c(), rand_axis_c(), rand_axis_c());
      endcase
      phase_items = N_RANDOM / 8;
      queue_random(phase_items / 2);
      // hold the sender until every point is back, then resume
      wait (pending_dirs.size() == 0 && !dir_ch.valid && expected_points.size() == 0);
      queue_random(phase_items - phase_items / 2);
      drain_pipe();
    end

    $display("Covered %0d support points over reset, directed and 8 random setups,",
             points_seen);
    $display("with bursty input, output stalls and saturating centers.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
